// File: rtl/core/rcr_pkg.sv
`default_nettype none
package rcr_pkg;

  localparam int MAP_SIDE     = 16;
  localparam int MAX_STEPS    = 160;
  localparam int MAX_ROWS     = 64;
  localparam int CELL_UNITS   = 163840;
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_START = 9949;
  localparam int DIV_BITS     = 26;
  localparam int MAC_TERMS    = 24;
  localparam int SORT_PAIRS   = 6;
  localparam int SQRT_STEPS   = 17;

  // configuration register indexes
  typedef enum logic [3:0] {
    CFG_MAP_A   = 4'd0,
    CFG_MAP_B   = 4'd1,
    CFG_MAP_C   = 4'd2,
    CFG_MAP_D   = 4'd3,
    CFG_COLUMNS = 4'd4,
    CFG_ROWS    = 4'd5,
    CFG_FOV     = 4'd6,
    CFG_TOL     = 4'd7
  } rcr_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_ANG, ST_CORDIC_INIT, ST_CORDIC, ST_MARCH_INIT, ST_MARCH,
    ST_MAC, ST_SORT, ST_SQRT_INIT, ST_SQRT, ST_TOL_MUL, ST_TOL_CMP,
    ST_CEIL_INIT, ST_DIV_CEIL, ST_EMIT_INIT, ST_EMIT
  } rcr_state_e;

  typedef struct packed {
    logic [255:0] map;
    logic [10:0]  cols;  // zero already mapped to one
    logic [6:0]   rows;  // already clamped
    logic [15:0]  fov;
    logic [15:0]  tol;
  } rcr_cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic cordic_init;
    logic cordic_step;
    logic march_init;
    logic march_step;
    logic mac_step;
    logic sort_step;
    logic sqrt_init;
    logic sqrt_step;
    logic tol_mul;
    logic tol_cmp;
    logic ceil_init;
    logic emit_init;
    logic emit_step;
  } rcr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cordic_last;
    logic march_stop;
    logic march_hit;
    logic mac_last;
    logic sort_last;
    logic sqrt_last;
    logic corner_last;
    logic emit_last;
    logic out_free;
  } rcr_sts_t;

  // cordic arctangent table, 65536 per turn
  function automatic logic [13:0] arc_tab(input logic [3:0] i);
    logic [13:0] r;
    unique case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // exchange sort pair order, {i, j}
  function automatic logic [3:0] sort_pair(input logic [2:0] k);
    logic [3:0] r;
    unique case (k)
      3'd0:    r = {2'd0, 2'd1};
      3'd1:    r = {2'd0, 2'd2};
      3'd2:    r = {2'd0, 2'd3};
      3'd3:    r = {2'd1, 2'd2};
      3'd4:    r = {2'd1, 2'd3};
      default: r = {2'd2, 2'd3};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rcr_ctrl.sv
`default_nettype none
module rcr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rcr_pkg::rcr_sts_t sts_i,
  output rcr_pkg::rcr_cmd_t      cmd_o
);
  import rcr_pkg::*;

  rcr_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV_ANG;
        end
      end
      ST_DIV_ANG: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_CORDIC_INIT;
      end
      ST_CORDIC_INIT: begin
        cmd_o.cordic_init = 1'b1;
        state_d           = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) state_d = ST_MARCH_INIT;
      end
      ST_MARCH_INIT: begin
        cmd_o.march_init = 1'b1;
        state_d          = ST_MARCH;
      end
      ST_MARCH: begin
        cmd_o.march_step = 1'b1;
        if (sts_i.march_stop) state_d = sts_i.march_hit ? ST_MAC : ST_CEIL_INIT;
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_last) state_d = ST_SORT;
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_last) state_d = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd_o.sqrt_init = 1'b1;
        state_d         = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = ST_TOL_MUL;
      end
      ST_TOL_MUL: begin
        cmd_o.tol_mul = 1'b1;
        state_d       = ST_TOL_CMP;
      end
      ST_TOL_CMP: begin
        cmd_o.tol_cmp = 1'b1;
        state_d       = sts_i.corner_last ? ST_CEIL_INIT : ST_SQRT_INIT;
      end
      ST_CEIL_INIT: begin
        cmd_o.ceil_init = 1'b1;
        state_d         = ST_DIV_CEIL;
      end
      ST_DIV_CEIL: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_EMIT_INIT;
      end
      ST_EMIT_INIT: begin
        cmd_o.emit_init = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/rcr_dp.sv
`default_nettype none
module rcr_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rcr_pkg::rcr_cmd_t cmd_i,
  output rcr_pkg::rcr_sts_t      sts_o,
  input  wire rcr_pkg::rcr_cfg_t cfg_i,
  input  wire logic [15:0]       player_x_i,
  input  wire logic [15:0]       player_y_i,
  input  wire logic [15:0]       view_angle_i,
  input  wire logic [9:0]        column_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [5:0]             row_index_o,
  output logic [3:0]             shade_code_o,
  output logic                   last_row_o,
  output logic [7:0]             hit_steps_o
);
  import rcr_pkg::*;

  logic [15:0] px_q, py_q, view_q;

  // ---------------- shared restoring divider
  logic [DIV_BITS-1:0] quo_q;
  logic [10:0]         rem_q, den_q;
  logic [4:0]          div_cnt_q;
  logic [11:0]         div_sh, div_trial;
  logic                div_ge;

  // ceiling numerator h*s - 20h
  logic [14:0] hs;
  logic [14:0] h20;
  logic [14:0] num;
  logic        num_pos;

  assign div_sh    = {rem_q, quo_q[DIV_BITS-1]};
  assign div_ge    = div_sh >= {1'b0, den_q};
  assign div_trial = div_sh - {1'b0, den_q};

  logic [7:0] steps_q;
  assign hs      = {8'b0, cfg_i.rows} * {7'b0, steps_q};
  assign h20     = {8'b0, cfg_i.rows} * 15'd20;
  assign num_pos = hs > h20;
  assign num     = hs - h20;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q      <= player_x_i;
      py_q      <= player_y_i;
      view_q    <= view_angle_i;
      quo_q     <= {16'b0, column_index_i} * {10'b0, cfg_i.fov};
      rem_q     <= '0;
      den_q     <= cfg_i.cols;
      div_cnt_q <= '0;
    end else if (cmd_i.ceil_init) begin
      quo_q     <= num_pos ? DIV_BITS'(num) : '0;
      rem_q     <= '0;
      den_q     <= {2'b0, steps_q, 1'b0};
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= div_ge ? div_trial[10:0] : div_sh[10:0];
      quo_q     <= {quo_q[DIV_BITS-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 5'd1;
    end
  end
  assign sts_o.div_last = div_cnt_q == 5'(DIV_BITS - 1);

  // ---------------- cordic sine and cosine
  logic [15:0]        ang, ang_r;
  logic               ang_flip;
  logic signed [17:0] cx_q, cy_q, cz_q, cx_sh, cy_sh, arc;
  logic [3:0]         it_q;
  logic               flip_q;

  assign ang      = view_q + {1'b0, cfg_i.fov[15:1]} - quo_q[15:0];
  assign ang_flip = ang[15] ^ ang[14];
  assign ang_r    = {ang[15] ^ ang_flip, ang[14:0]};
  assign cx_sh    = cx_q >>> it_q;
  assign cy_sh    = cy_q >>> it_q;
  assign arc      = $signed({4'b0, arc_tab(it_q)});

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_init) begin
      cx_q   <= 18'sd9949;
      cy_q   <= '0;
      cz_q   <= 18'($signed(ang_r));
      it_q   <= '0;
      flip_q <= ang_flip;
    end else if (cmd_i.cordic_step) begin
      if (cz_q >= 0) begin
        cx_q <= cx_q - cy_sh;
        cy_q <= cy_q + cx_sh;
        cz_q <= cz_q - arc;
      end else begin
        cx_q <= cx_q + cy_sh;
        cy_q <= cy_q - cx_sh;
        cz_q <= cz_q + arc;
      end
      it_q <= it_q + 4'd1;
    end
  end
  assign sts_o.cordic_last = it_q == 4'(CORDIC_STEPS - 1);

  // ---------------- ray march, cell and remainder tracked per axis
  logic signed [17:0] ex_q, ey_q;
  logic [17:0]        rx_q, ry_q;
  logic signed [5:0]  gx_q, gy_q, ngx, ngy;
  logic signed [19:0] sx, sy, nrx, nry;
  logic [7:0]         d_q;
  logic [3:0]         hx_q, hy_q;
  logic               m_out, m_wall;
  localparam logic signed [19:0] CellU = 20'(CELL_UNITS);
  localparam logic signed [5:0]  SideS = 6'(MAP_SIDE);

  assign sx = $signed({2'b0, rx_q}) + 20'(ex_q);
  assign sy = $signed({2'b0, ry_q}) + 20'(ey_q);

  always_comb begin
    ngx = gx_q;
    nrx = sx;
    if (sx < 0) begin
      ngx = gx_q - 6'sd1;
      nrx = sx + CellU;
    end else if (sx >= CellU) begin
      ngx = gx_q + 6'sd1;
      nrx = sx - CellU;
    end
    ngy = gy_q;
    nry = sy;
    if (sy < 0) begin
      ngy = gy_q - 6'sd1;
      nry = sy + CellU;
    end else if (sy >= CellU) begin
      ngy = gy_q + 6'sd1;
      nry = sy - CellU;
    end
  end

  assign m_out  = (ngx < 0) || (ngy < 0) || (ngx >= SideS) || (ngy >= SideS);
  assign m_wall = cfg_i.map[{ngy[3:0], ngx[3:0]}];

  always_ff @(posedge clk_i) begin
    if (cmd_i.march_init) begin
      ex_q    <= flip_q ? -cy_q : cy_q;
      ey_q    <= flip_q ? -cx_q : cx_q;
      gx_q    <= $signed({2'b0, px_q[15:12]});
      gy_q    <= $signed({2'b0, py_q[15:12]});
      rx_q    <= {6'b0, px_q[11:0]} * 18'd40;
      ry_q    <= {6'b0, py_q[11:0]} * 18'd40;
      d_q     <= 8'd1;
      steps_q <= 8'(MAX_STEPS);
    end else if (cmd_i.march_step) begin
      rx_q <= nrx[17:0];
      ry_q <= nry[17:0];
      gx_q <= ngx;
      gy_q <= ngy;
      d_q  <= d_q + 8'd1;
      if (!m_out && m_wall) begin
        hx_q    <= ngx[3:0];
        hy_q    <= ngy[3:0];
        steps_q <= d_q;
      end
    end
  end
  assign sts_o.march_stop = m_out || m_wall || (d_q == 8'(MAX_STEPS));
  assign sts_o.march_hit  = !m_out && m_wall;

  // ---------------- corner products, one multiplier, registered then summed
  logic [1:0]         mc_q, pc_q;
  logic [2:0]         mt_q, pt_q;
  logic [4:0]         mac_cnt_q;
  logic               pv_q;
  logic signed [17:0] vx, vy, op_a, op_b;
  logic signed [35:0] prod_q;
  logic signed [36:0] key_q [4];
  logic signed [36:0] dot_q [4];
  logic signed [36:0] crs_q [4];

  assign vx = $signed({1'b0, {1'b0, hx_q} + {4'b0, mc_q[1]}, 12'b0}) - $signed({2'b0, px_q});
  assign vy = $signed({1'b0, {1'b0, hy_q} + {4'b0, mc_q[0]}, 12'b0}) - $signed({2'b0, py_q});

  always_comb begin
    unique case (mt_q)
      3'd0:    begin op_a = vx;   op_b = vx; end
      3'd1:    begin op_a = vy;   op_b = vy; end
      3'd2:    begin op_a = ex_q; op_b = vx; end
      3'd3:    begin op_a = ey_q; op_b = vy; end
      3'd4:    begin op_a = ex_q; op_b = vy; end
      default: begin op_a = ey_q; op_b = vx; end
    endcase
  end

  // sort pair selection
  logic [3:0] sp;
  logic [2:0] sort_cnt_q;
  logic [1:0] si, sj;
  assign sp = sort_pair(sort_cnt_q);
  assign si = sp[3:2];
  assign sj = sp[1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.march_init) begin
      mc_q       <= '0;
      mt_q       <= '0;
      mac_cnt_q  <= '0;
      pv_q       <= 1'b0;
      sort_cnt_q <= '0;
    end else if (cmd_i.mac_step) begin
      if (mac_cnt_q < 5'(MAC_TERMS)) begin
        prod_q <= op_a * op_b;
        pc_q   <= mc_q;
        pt_q   <= mt_q;
        pv_q   <= 1'b1;
        if (mt_q == 3'd5) begin
          mt_q <= '0;
          mc_q <= mc_q + 2'd1;
        end else begin
          mt_q <= mt_q + 3'd1;
        end
      end else begin
        pv_q <= 1'b0;
      end
      mac_cnt_q <= mac_cnt_q + 5'd1;
      if (pv_q) begin
        unique case (pt_q)
          3'd0:    key_q[pc_q] <= 37'(prod_q);
          3'd1:    key_q[pc_q] <= key_q[pc_q] + 37'(prod_q);
          3'd2:    dot_q[pc_q] <= 37'(prod_q);
          3'd3:    dot_q[pc_q] <= dot_q[pc_q] + 37'(prod_q);
          3'd4:    crs_q[pc_q] <= 37'(prod_q);
          default: crs_q[pc_q] <= crs_q[pc_q] - 37'(prod_q);
        endcase
      end
    end else if (cmd_i.sort_step) begin
      // swap whole corner records so the order carries key, dot and cross
      if (key_q[si] > key_q[sj]) begin
        key_q[si] <= key_q[sj];
        key_q[sj] <= key_q[si];
        dot_q[si] <= dot_q[sj];
        dot_q[sj] <= dot_q[si];
        crs_q[si] <= crs_q[sj];
        crs_q[sj] <= crs_q[si];
      end
      sort_cnt_q <= sort_cnt_q + 3'd1;
    end
  end
  assign sts_o.mac_last  = mac_cnt_q == 5'(MAC_TERMS);
  assign sts_o.sort_last = sort_cnt_q == 3'(SORT_PAIRS - 1);

  // ---------------- corner test: integer square root and tolerance compare
  logic               q_q, edge_q, cond_q;
  logic [33:0]        sv_q, sr_q, sb_q, st;
  logic [4:0]         sq_cnt_q;
  logic [35:0]        acrs_q;
  logic [33:0]        tp_q;
  logic signed [36:0] k_sel, d_sel, c_sel;

  assign k_sel = q_q ? key_q[1] : key_q[0];
  assign d_sel = q_q ? dot_q[1] : dot_q[0];
  assign c_sel = q_q ? crs_q[1] : crs_q[0];
  assign st    = sr_q + sb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q    <= 1'b0;
      edge_q <= 1'b0;
    end else if (cmd_i.sqrt_init) begin
      sv_q     <= k_sel[33:0];
      sr_q     <= '0;
      sb_q     <= 34'h1_0000_0000;
      sq_cnt_q <= '0;
      cond_q   <= (k_sel > 0) && (d_sel > 0);
      acrs_q   <= c_sel < 0 ? 36'(-c_sel) : 36'(c_sel);
    end else if (cmd_i.sqrt_step) begin
      if (sv_q >= st) begin
        sv_q <= sv_q - st;
        sr_q <= (sr_q >> 1) + sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q     <= sb_q >> 2;
      sq_cnt_q <= sq_cnt_q + 5'd1;
    end else if (cmd_i.tol_mul) begin
      tp_q <= {18'b0, cfg_i.tol} * {16'b0, sr_q[17:0]};
    end else if (cmd_i.tol_cmp) begin
      if (cond_q && ({1'b0, acrs_q, 2'b00} < {5'b0, tp_q})) edge_q <= 1'b1;
      q_q <= 1'b1;
    end
  end
  assign sts_o.sqrt_last   = sq_cnt_q == 5'(SQRT_STEPS - 1);
  assign sts_o.corner_last = q_q;

  // ---------------- row emission
  logic [5:0]  y_q, ceil_q;
  logic [6:0]  floor_r, g;
  logic [3:0]  shade, code;
  logic [11:0] g12, h12;
  logic        out_valid_q;

  always_comb begin
    if ({2'b0, steps_q} * 10'd4 < 10'(MAX_STEPS))      shade = 4'd1;
    else if ({2'b0, steps_q} * 10'd3 < 10'(MAX_STEPS)) shade = 4'd2;
    else if ({2'b0, steps_q} * 10'd2 < 10'(MAX_STEPS)) shade = 4'd3;
    else if (steps_q < 8'(MAX_STEPS))                  shade = 4'd4;
    else                                               shade = 4'd5;
    if (edge_q) shade = 4'd6;
  end

  assign floor_r = cfg_i.rows - {1'b0, ceil_q};
  assign g       = cfg_i.rows - {1'b0, y_q};
  assign g12     = {5'b0, g};
  assign h12     = {5'b0, cfg_i.rows};

  always_comb begin
    if (y_q < ceil_q)                       code = 4'd0;
    else if ({1'b0, y_q} <= floor_r)        code = shade;
    else if (g12 * 12'd8 < h12)             code = 4'd7;
    else if (g12 * 12'd4 < h12)             code = 4'd8;
    else if (g12 * 12'd8 < h12 * 12'd3)     code = 4'd9;
    else if (g12 * 12'd20 < h12 * 12'd9)    code = 4'd10;
    else                                    code = 4'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_init) begin
      ceil_q <= quo_q[5:0];
      y_q    <= '0;
    end else if (cmd_i.emit_step) begin
      row_index_o  <= y_q;
      shade_code_o <= code;
      last_row_o   <= sts_o.emit_last;
      hit_steps_o  <= steps_q;
      y_q          <= y_q + 6'd1;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = {1'b0, y_q} == cfg_i.rows - 7'd1;

endmodule
`default_nettype wire

// File: rtl/core/raycast_column_renderer_unit.sv
`default_nettype none
// channel   | direction | transaction
// s_axis    | in        | player_x, player_y, view_angle, column_index
// m_axis    | out       | one shade code per screen row, tlast on the last row
// cfg       | in        | register index and write data, always ready
//
// a column is processed in order: accept, angle divide, cordic, march of up to
// 160 steps (one step a cycle), corner test on a hit, ceiling divide, then one
// row per cycle out of the output register while the output is not stalled. a
// new item is taken only once the previous column has been fully queued. output
// stalls hold the row emitter; reset clears the controller, the output valid and
// the configuration registers to their defaults.
module raycast_column_renderer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // player_x[15:0], player_y[31:16], view_angle[47:32], column_index[57:48]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // row_index[5:0], shade_code[9:6], hit_steps[17:10]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import rcr_pkg::*;

  logic [63:0] map_q [4];
  logic [10:0] cols_q;
  logic [6:0]  rows_q;
  logic [15:0] fov_q, tol_q;
  rcr_cfg_t    cfg;
  rcr_cmd_t    cmd;
  rcr_sts_t    sts;
  logic [5:0]  row_index;
  logic [3:0]  shade_code;
  logic [7:0]  hit_steps;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q[0] <= '0;
      map_q[1] <= '0;
      map_q[2] <= '0;
      map_q[3] <= '0;
      cols_q   <= 11'd120;
      rows_q   <= 7'd40;
      fov_q    <= 16'd8192;
      tol_q    <= 16'd66;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAP_A:   map_q[0] <= cfg_data_i;
        CFG_MAP_B:   map_q[1] <= cfg_data_i;
        CFG_MAP_C:   map_q[2] <= cfg_data_i;
        CFG_MAP_D:   map_q[3] <= cfg_data_i;
        CFG_COLUMNS: cols_q   <= cfg_data_i[10:0];
        CFG_ROWS:    rows_q   <= cfg_data_i[6:0];
        CFG_FOV:     fov_q    <= cfg_data_i[15:0];
        CFG_TOL:     tol_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective settings: zero columns as one, rows clamped
  always_comb begin
    cfg.map  = {map_q[3], map_q[2], map_q[1], map_q[0]};
    cfg.cols = (cols_q == '0) ? 11'd1 : cols_q;
    if (rows_q < 7'd2)                 cfg.rows = 7'd2;
    else if (rows_q > 7'(MAX_ROWS))    cfg.rows = 7'(MAX_ROWS);
    else                               cfg.rows = rows_q;
    cfg.fov  = fov_q;
    cfg.tol  = tol_q;
  end

  rcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rcr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg),
    .player_x_i     (s_axis_tdata[15:0]),
    .player_y_i     (s_axis_tdata[31:16]),
    .view_angle_i   (s_axis_tdata[47:32]),
    .column_index_i (s_axis_tdata[57:48]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .row_index_o    (row_index),
    .shade_code_o   (shade_code),
    .last_row_o     (m_axis_tlast),
    .hit_steps_o    (hit_steps)
  );

  assign m_axis_tdata = {6'b0, hit_steps, shade_code, row_index};

  // busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // last row flag lines up with the row count
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> {1'b0, row_index} == cfg.rows - 7'd1)
    else $error("last row flag on wrong row");

  // shade code and distance stay in range
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> shade_code <= 4'd10 && hit_steps <= 8'(MAX_STEPS))
    else $error("result out of range");

endmodule
`default_nettype wire
